### rtl/core/uvst_pkg.sv
// shared types and constants for the unique value set table
package uvst_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic               stored;
        logic               already_present;
        logic               table_full;
        logic [VALUE_W-1:0] read_value;
        logic               read_valid;
        logic [COUNT_W-1:0] count;
    } rslt_t;

endpackage

### rtl/core/uvst_ram.sv
// generic single write port, single read port ram with registered read
module uvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/uvst_fifo.sv
// small register queue used between the front, the back and the result side
module uvst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/uvst_front.sv
// front end: accepts input transactions, classifies them and queues commands
module uvst_front
    import uvst_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic [VALUE_W-1:0] value,
    input  logic [INDEX_W-1:0] index,
    input  logic               cmd_pop,
    output logic               cmd_empty,
    output cmd_t               cmd_head
);

    localparam int EXT_W = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

    logic [EXT_W-1:0]       value_ext;
    cmd_t                   cmd_in;
    logic [$bits(cmd_t)-1:0] head_bits;

    assign value_ext = EXT_W'(value);

    always_comb
    begin
        cmd_in.op    = action;
        cmd_in.index = index;
        cmd_in.value = '0;
        if (action == OP_INSERT)
        begin
            // only the low element bits take part in the compare
            cmd_in.value = VALUE_W'(value_ext[ELEM_WIDTH-1:0]);
        end
    end

    uvst_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (head_bits),
        .empty (cmd_empty)
    );

    assign cmd_head = cmd_t'(head_bits);

endmodule

### rtl/core/uvst_back.sv
// back end: scans the entry store, appends new values and serves reads
module uvst_back
    import uvst_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_empty,
    input  cmd_t  cmd_head,
    output logic  cmd_pop,
    input  logic  res_full,
    output logic  res_push,
    output rslt_t res_data
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam int IW    = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int AXW   = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int OCW   = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    cmd_t        cur_reg, cur_next;
    rslt_t       rs_reg, rs_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;
    logic [ELEM_WIDTH-1:0] elem;
    logic [EXT_W-1:0]      value_ext, rdata_ext;
    logic [AXW-1:0]        index_ext;
    logic [OCW-1:0]        count_ext;
    logic                  index_ok;
    logic                  do_decide;

    assign value_ext = EXT_W'(cur_reg.value);
    assign elem      = value_ext[ELEM_WIDTH-1:0];
    assign rdata_ext = EXT_W'(ram_rdata);
    assign index_ext = AXW'(cur_reg.index);
    assign index_ok  = (IW'(cur_reg.index) < IW'(count_reg));
    assign count_ext = OCW'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        cur_next   = cur_reg;
        rs_next    = rs_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_raddr  = ptr_reg[AW-1:0];
        do_decide  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd_head;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                rs_next = '0;
                if (cur_reg.op == OP_READ)
                begin
                    if (index_ok)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = index_ext[AW-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (count_reg == '0)
                begin
                    do_decide  = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    ptr_next   = CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // ram data here belongs to entry ptr_reg - 1
                if (ram_rdata == elem)
                begin
                    rs_next.already_present = 1'b1;
                    state_next              = S_PUSH;
                end
                else if (ptr_reg == count_reg)
                begin
                    do_decide  = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    ram_re   = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_READ:
            begin
                rs_next.read_value = rdata_ext[VALUE_W-1:0];
                rs_next.read_valid = 1'b1;
                state_next         = S_PUSH;
            end
            S_PUSH:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // value absent: append if there is room, else refuse
        if (do_decide)
        begin
            if (count_reg < CW'(CAPACITY))
            begin
                ram_we         = 1'b1;
                count_next     = count_reg + 1'b1;
                rs_next.stored = 1'b1;
            end
            else
            begin
                rs_next.table_full = 1'b1;
            end
        end
    end

    always_comb
    begin
        res_data       = rs_reg;
        res_data.count = count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rs_reg  <= rs_next;
    end

    uvst_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entry_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (elem),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/core/unique_value_set_table.sv
// top level of the unique value set table
// A bounded set of unique values kept in insertion order. An insert (action 0)
// compares the value against every stored entry and appends it only when it is
// absent and there is room; the result flags say stored, already present or
// refused because the table is full. A read (action 1) returns the entry at
// index with read_valid set when index is below the count. Every result carries
// the entry count after the transaction. Both sides behave like queues: push and
// full on the input, empty and pop on the result side, each with a two-entry
// buffer. The entry store is a single read port ram scanned one entry per cycle,
// so an insert of an absent value scans every stored entry, a match ends the
// scan early, and a read fetches at most the one entry at index.
// The back end works on one transaction at a time, so the next one starts only
// after the previous result has gone into the result buffer, and a full result
// buffer holds the back end until pop frees a slot.
module unique_value_set_table
    import uvst_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic [VALUE_W-1:0] value,
    input  logic [INDEX_W-1:0] index,
    output logic               empty,
    input  logic               pop,
    output logic               stored,
    output logic               already_present,
    output logic               table_full,
    output logic [VALUE_W-1:0] read_value,
    output logic               read_valid,
    output logic [COUNT_W-1:0] count
);

    logic                     cmd_empty, cmd_pop;
    cmd_t                     cmd_head;
    logic                     res_full, res_push;
    rslt_t                    res_data, res_head;
    logic [$bits(rslt_t)-1:0] res_bits;

    uvst_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .value     (value),
        .index     (index),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head)
    );

    uvst_back #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    uvst_fifo #(
        .WIDTH ($bits(rslt_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_head        = rslt_t'(res_bits);
    assign stored          = res_head.stored;
    assign already_present = res_head.already_present;
    assign table_full      = res_head.table_full;
    assign read_value      = res_head.read_value;
    assign read_valid      = res_head.read_valid;
    assign count           = res_head.count;

endmodule

### verif/set_table_checker.sv
// transaction checker for the unique value set table: predicts each result and compares it
`timescale 1ns / 100ps

module set_table_checker
    import uvst_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               action,
    input  logic [VALUE_W-1:0] value,
    input  logic [INDEX_W-1:0] index,
    input  logic               empty,
    input  logic               pop,
    input  logic               stored,
    input  logic               already_present,
    input  logic               table_full,
    input  logic [VALUE_W-1:0] read_value,
    input  logic               read_valid,
    input  logic [COUNT_W-1:0] count,
    output int                 mismatches,
    output int                 outstanding
);

    logic [VALUE_W-1:0] set_entries [CAPACITY];
    logic [COUNT_W-1:0] set_size = '0;
    rslt_t              awaited_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void flag_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function automatic void compare_field(input string name, input logic [VALUE_W-1:0] want,
                                          input logic [VALUE_W-1:0] got);
        if (got !== want)
            flag_failure($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    // applies one command to the modeled set and returns the result it should produce
    function automatic rslt_t apply_set_command(input logic op, input logic [VALUE_W-1:0] val,
                                                input logic [INDEX_W-1:0] idx);
        rslt_t res;
        logic  hit;
        int    k;
        res = '0;
        hit = 1'b0;
        if (op == OP_INSERT)
        begin
            for (k = 0; k < set_size; k++)
            begin
                if (set_entries[k] == val)
                    hit = 1'b1;
            end
            if (hit)
                res.already_present = 1'b1;
            else if (set_size < CAPACITY)
            begin
                set_entries[set_size] = val;
                set_size++;
                res.stored = 1'b1;
            end
            else
                res.table_full = 1'b1;
        end
        else if (idx < set_size)
        begin
            res.read_value = set_entries[idx];
            res.read_valid = 1'b1;
        end
        res.count = set_size;
        return res;
    endfunction

    always @(posedge clk)
    begin
        rslt_t want;
        if (rst_n)
        begin
            if (push && !full)
                awaited_results.push_back(apply_set_command(action, value, index));
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                    flag_failure("result transaction with none expected");
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("stored", want.stored, stored);
                    compare_field("already_present", want.already_present, already_present);
                    compare_field("table_full", want.table_full, table_full);
                    compare_field("read_value", want.read_value, read_value);
                    compare_field("read_valid", want.read_valid, read_valid);
                    compare_field("count", want.count, count);
                end
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

### verif/unique_value_set_table_test.sv
// top of the unique value set table testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module unique_value_set_table_test;
    import uvst_pkg::*;

    localparam int RANDOM_ITEMS = 1384;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               push            = 1'b0;
    logic               action          = OP_INSERT;
    logic [VALUE_W-1:0] value           = '0;
    logic [INDEX_W-1:0] index           = '0;
    logic               pop             = 1'b0;
    logic               full;
    logic               empty;
    logic               stored;
    logic               already_present;
    logic               table_full;
    logic [VALUE_W-1:0] read_value;
    logic               read_valid;
    logic [COUNT_W-1:0] count;
    int                 mismatches;
    int                 outstanding;

    int                 sent_total     = 0;
    bit                 sender_burst   = 1'b0;
    bit                 receiver_burst = 1'b0;
    logic [VALUE_W-1:0] offered_values [$];

    unique_value_set_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .value           (value),
        .index           (index),
        .empty           (empty),
        .pop             (pop),
        .stored          (stored),
        .already_present (already_present),
        .table_full      (table_full),
        .read_value      (read_value),
        .read_valid      (read_valid),
        .count           (count)
    );

    set_table_checker results_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .value           (value),
        .index           (index),
        .empty           (empty),
        .pop             (pop),
        .stored          (stored),
        .already_present (already_present),
        .table_full      (table_full),
        .read_value      (read_value),
        .read_valid      (read_valid),
        .count           (count),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic offer_command(input logic op, input logic [VALUE_W-1:0] val,
                                 input logic [INDEX_W-1:0] idx);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        action <= op;
        value  <= val;
        index  <= idx;
        do
        begin
            @(posedge clk);
        end
        while (full);
        sent_total++;
        if (sent_total % 64 == 0)
            sender_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    // result side: random stalls, bursts with none, and one long hold-off
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 64 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            gap = receiver_burst ? 0 : $urandom_range(0, 15);
            // long hold so both buffers fill and full backs up to the sender
            if (taken == 300)
                gap = 600;
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (empty);
            taken++;
        end
    end

    initial
    begin
        int                 roll;
        int                 n;
        logic               op;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reads of an empty table, extreme values, duplicates, reads around the count
        offer_command(OP_READ, 32'hFFFF_FFFF, 7'd0);
        offer_command(OP_READ, 32'h0000_0000, 7'd127);
        offer_command(OP_INSERT, 32'h0000_0000, 7'd127);
        offer_command(OP_INSERT, 32'hFFFF_FFFF, 7'd0);
        offer_command(OP_INSERT, 32'h0000_0000, 7'd0);
        offer_command(OP_INSERT, 32'hFFFF_FFFF, 7'd127);
        offer_command(OP_INSERT, 32'h8000_0000, 7'd0);
        offer_command(OP_INSERT, 32'h0000_0001, 7'd0);
        offer_command(OP_INSERT, 32'h8000_0000, 7'd0);
        offer_command(OP_READ, 32'h0000_0000, 7'd0);
        offer_command(OP_READ, 32'h0000_0000, 7'd1);
        offer_command(OP_READ, 32'h0000_0000, 7'd2);
        offer_command(OP_READ, 32'h0000_0000, 7'd3);
        offer_command(OP_READ, 32'hFFFF_FFFF, 7'd4);
        offer_command(OP_READ, 32'h0000_0000, 7'd127);
        offer_command(OP_READ, 32'h0000_0000, 7'd100);
        offered_values.push_back(32'h0000_0000);
        offered_values.push_back(32'hFFFF_FFFF);
        offered_values.push_back(32'h8000_0000);
        offered_values.push_back(32'h0000_0001);
        wait_for_drain();

        // mix of fresh values, repeats and near misses; fills the table, then keeps
        // hitting it while full
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, 127);
            val  = $urandom;
            if (roll < 60)
            begin
                op   = OP_INSERT;
                roll = $urandom_range(0, 9);
                if (roll < 5)
                    val = offered_values[$urandom_range(0, offered_values.size() - 1)];
                else
                begin
                    // one-bit neighbor of a known value stresses the comparator
                    if (roll == 5)
                        val = offered_values[$urandom_range(0, offered_values.size() - 1)]
                              ^ (32'd1 << $urandom_range(0, 31));
                    offered_values.push_back(val);
                end
            end
            else
            begin
                op = OP_READ;
                if ($urandom_range(0, 3) == 0)
                    idx = $urandom_range(0, 15);
            end
            offer_command(op, val, idx);
            if (n == 700)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
